// ----- rtl/hpid_pkg.sv -----
package hpid_pkg;

	localparam logic signed [17:0] PI_Q12     = 18'sd12868;
	localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

	localparam int DERIV_SHIFT   = 4;
	localparam int DERIV_DIVISOR = 1 << DERIV_SHIFT;
	localparam int ROUND_SHIFT   = 12;
	localparam int ROUND_HALF    = 1 << (ROUND_SHIFT - 1);

	localparam logic [15:0] GAIN_P_RESET      = 16'd16384;
	localparam logic [15:0] GAIN_I_RESET      = 16'd737;
	localparam logic [15:0] GAIN_D_RESET      = 16'd5325;
	localparam logic [14:0] SPEED_LIMIT_RESET = 15'd24576;
	localparam logic [11:0] STEP_LIMIT_RESET  = 12'd205;
	localparam logic [11:0] RESET_BAND_RESET  = 12'd20;
	localparam logic [11:0] DONE_BAND_RESET   = 12'd4;

	typedef enum logic [2:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_SPEED_LIMIT = 3'd3,
		REG_STEP_LIMIT  = 3'd4,
		REG_RESET_BAND  = 3'd5,
		REG_DONE_BAND   = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [14:0] speed_limit;
		logic [11:0] step_limit;
		logic [11:0] reset_band;
		logic [11:0] done_band;
	} cfg_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] err;
		logic signed [16:0] diff;
		logic signed [23:0] integ;
	} err_bundle_t;

	typedef struct packed {
		logic               done;
		logic signed [32:0] prop;
		logic signed [40:0] integ;
		logic signed [33:0] deriv;
	} prod_bundle_t;

	function automatic logic signed [17:0] wrap_step(input logic signed [17:0] a);
		if (a <= -PI_Q12) begin
			return a + TWO_PI_Q12;
		end else if (a > PI_Q12) begin
			return a - TWO_PI_Q12;
		end else begin
			return a;
		end
	endfunction

endpackage

// ----- rtl/hpid_err_stage.sv -----
module hpid_err_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hpid_pkg::cfg_t       cfg,
	input  logic                 advance,
	input  logic signed [14:0]   yaw,
	input  logic signed [15:0]   target,
	output hpid_pkg::err_bundle_t res_s2
);
	import hpid_pkg::*;

	logic signed [17:0] yaw_w;
	logic signed [17:0] diff_raw;
	logic signed [17:0] err_w;
	logic signed [15:0] err;
	logic [14:0]        err_mag;
	logic               in_reset_band;
	logic               in_done_band;
	logic signed [12:0] lim;
	logic signed [12:0] inc;
	logic signed [24:0] sum;
	logic signed [23:0] sum_sat;
	logic signed [23:0] integ_next;
	logic signed [16:0] diff;
	logic signed [15:0] prev_error_q;
	logic signed [23:0] integ_q;

	always_comb begin
		yaw_w         = wrap_step(18'(yaw));
		diff_raw      = 18'(target) - yaw_w;
		err_w         = wrap_step(wrap_step(diff_raw));
		err           = err_w[15:0];
		err_mag       = err[15] ? 15'(-err) : 15'(err);
		in_reset_band = err_mag <= {3'b000, cfg.reset_band};
		in_done_band  = err_mag <= {3'b000, cfg.done_band};
		lim           = $signed({1'b0, cfg.step_limit});
		if (err > 16'(lim)) begin
			inc = lim;
		end else if (err < -16'(lim)) begin
			inc = -lim;
		end else begin
			inc = 13'(err);
		end
		sum = 25'(integ_q) + 25'(inc);
		if (sum[24] != sum[23]) begin
			sum_sat = sum[24] ? 24'sh800000 : 24'sh7FFFFF;
		end else begin
			sum_sat = sum[23:0];
		end
		integ_next = (in_reset_band || in_done_band) ? '0 : sum_sat;
		diff       = 17'(err) - 17'(prev_error_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integ_q      <= '0;
		end else if (advance) begin
			prev_error_q <= in_done_band ? prev_error_q : err;
			integ_q      <= integ_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.done  <= in_done_band;
			res_s2.err   <= err;
			res_s2.diff  <= diff;
			res_s2.integ <= integ_next;
		end
	end

endmodule

// ----- rtl/hpid_mult_stage.sv -----
module hpid_mult_stage (
	input  logic                   clk,
	input  hpid_pkg::cfg_t         cfg,
	input  logic                   advance,
	input  hpid_pkg::err_bundle_t  res_s2,
	output hpid_pkg::prod_bundle_t res_s3
);
	import hpid_pkg::*;

	logic signed [32:0] prop;
	logic signed [40:0] integ;
	logic signed [33:0] deriv;

	always_comb begin
		prop  = $signed({1'b0, cfg.gain_p}) * res_s2.err;
		integ = $signed({1'b0, cfg.gain_i}) * res_s2.integ;
		deriv = $signed({1'b0, cfg.gain_d}) * res_s2.diff;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s3.done  <= res_s2.done;
			res_s3.prop  <= prop;
			res_s3.integ <= integ;
			res_s3.deriv <= deriv;
		end
	end

endmodule

// ----- rtl/hpid_out_stage.sv -----
module hpid_out_stage (
	input  logic                   clk,
	input  hpid_pkg::cfg_t         cfg,
	input  logic                   advance,
	input  hpid_pkg::prod_bundle_t res_s3,
	output logic signed [15:0]     left_q,
	output logic signed [15:0]     right_q,
	output logic                   done_q
);
	import hpid_pkg::*;

	logic signed [41:0] dext;
	logic signed [41:0] bias;
	logic signed [41:0] dterm;
	logic signed [41:0] acc;
	logic signed [41:0] rnd;
	logic signed [41:0] lim_pos;
	logic signed [41:0] lim_neg;
	logic signed [15:0] speed;

	always_comb begin
		dext    = 42'(res_s3.deriv);
		bias    = res_s3.deriv[33] ? 42'(DERIV_DIVISOR - 1) : '0;
		dterm   = (dext + bias) >>> DERIV_SHIFT;
		acc     = 42'(res_s3.prop) + 42'(res_s3.integ) + dterm;
		rnd     = (acc + 42'(ROUND_HALF)) >>> ROUND_SHIFT;
		lim_pos = $signed({27'd0, cfg.speed_limit});
		lim_neg = -lim_pos;
		if (rnd > lim_pos) begin
			speed = lim_pos[15:0];
		end else if (rnd < lim_neg) begin
			speed = lim_neg[15:0];
		end else begin
			speed = rnd[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (res_s3.done) begin
				left_q  <= '0;
				right_q <= '0;
				done_q  <= 1'b1;
			end else begin
				left_q  <= -speed;
				right_q <= speed;
				done_q  <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/heading_pid_turn_controller.sv -----
// Heading PID turn controller.
// Input beat: measured_yaw (Q.12 rad) and target_yaw (Q.12 rad) on in_valid/in_ready.
// Output beat: left_speed, right_speed (Q.12 rad/s) and turn_done on out_valid/out_ready.
// The heading error is wrapped into (-pi, pi] and fed to a PID law with a clamped,
// saturating integral; within the done band the wheels stop and turn_done is set.
// Gains, limits and bands are written through cfg_write/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// A beat passes the input register, error/integral stage, multiply stage and output
// register. Throughput: one beat per cycle unless out_ready stalls the output; the
// integral and previous error update in the error stage as each beat passes, so
// each beat sees the state left by the one before. When out_ready is low, the
// output register holds and each stage keeps taking beats until it is full,
// then in_ready drops. Reset clears the integral, the previous error, all valid
// bits and restores the default gains, limits and bands.
module heading_pid_turn_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [14:0] measured_yaw,
	input  logic signed [15:0] target_yaw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_speed,
	output logic signed [15:0] right_speed,
	output logic               turn_done,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import hpid_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic signed [14:0] yaw_s1;
	logic signed [15:0] target_s1;
	err_bundle_t        res_s2;
	prod_bundle_t       res_s3;
	logic               rdy_out;
	logic               rdy_s3;
	logic               rdy_s2;
	logic               adv_s1;
	logic               adv_s2;
	logic               adv_s3;
	logic               in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p      <= GAIN_P_RESET;
			cfg_q.gain_i      <= GAIN_I_RESET;
			cfg_q.gain_d      <= GAIN_D_RESET;
			cfg_q.speed_limit <= SPEED_LIMIT_RESET;
			cfg_q.step_limit  <= STEP_LIMIT_RESET;
			cfg_q.reset_band  <= RESET_BAND_RESET;
			cfg_q.done_band   <= DONE_BAND_RESET;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_GAIN_P:      cfg_q.gain_p      <= cfg_data;
				REG_GAIN_I:      cfg_q.gain_i      <= cfg_data;
				REG_GAIN_D:      cfg_q.gain_d      <= cfg_data;
				REG_SPEED_LIMIT: cfg_q.speed_limit <= cfg_data[14:0];
				REG_STEP_LIMIT:  cfg_q.step_limit  <= cfg_data[11:0];
				REG_RESET_BAND:  cfg_q.reset_band  <= cfg_data[11:0];
				REG_DONE_BAND:   cfg_q.done_band   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rdy_out  = !out_valid || out_ready;
		adv_s3   = valid_s3 && rdy_out;
		rdy_s3   = !valid_s3 || rdy_out;
		adv_s2   = valid_s2 && rdy_s3;
		rdy_s2   = !valid_s2 || rdy_s3;
		adv_s1   = valid_s1 && rdy_s2;
		in_ready = !valid_s1 || rdy_s2;
		in_fire  = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s3 <= 1'b1;
			end else if (adv_s3) begin
				valid_s3 <= 1'b0;
			end
			if (adv_s3) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			yaw_s1    <= measured_yaw;
			target_s1 <= target_yaw;
		end
	end

	hpid_err_stage u_err (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (adv_s1),
		.yaw     (yaw_s1),
		.target  (target_s1),
		.res_s2  (res_s2)
	);

	hpid_mult_stage u_mult (
		.clk     (clk),
		.cfg     (cfg_q),
		.advance (adv_s2),
		.res_s2  (res_s2),
		.res_s3  (res_s3)
	);

	hpid_out_stage u_out (
		.clk     (clk),
		.cfg     (cfg_q),
		.advance (adv_s3),
		.res_s3  (res_s3),
		.left_q  (left_speed),
		.right_q (right_speed),
		.done_q  (turn_done)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && turn_done |-> left_speed == 16'sd0 && right_speed == 16'sd0)
		else $error("wheels not stopped on a finished turn");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_speed == -right_speed)
		else $error("left speed is not the negated right speed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 17'(right_speed) <= $signed({2'b00, cfg_q.speed_limit})
			&& 17'(right_speed) >= -$signed({2'b00, cfg_q.speed_limit}))
		else $error("speed outside the configured limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rdy_s3 |=> valid_s2 && $stable(res_s2))
		else $error("error stage lost a stalled beat");

endmodule
